// ===== rtl/hpq_pkg.sv =====
// Shared types and constants for the max-heap priority queue.
// Used by hpq_cell and max_heap_priority_queue_top; depends on nothing.
package hpq_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ECNT_W   = 7;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic                    push;
      logic                    pop;
      logic signed [KEY_W-1:0] key;
   } cell_ctrl_type;

   typedef struct packed {
      logic                    valid;
      logic                    ins;
      logic signed [KEY_W-1:0] value;
   } cell_link_type;

endpackage

// ===== rtl/hpq_cell.sv =====
// One cell of the sorted key chain: holds one key and its valid bit.
// Depends on hpq_pkg for the control and neighbor link structs.
module hpq_cell
   import hpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  cell_link_type left_link,
   input  cell_link_type right_link,
   output cell_link_type link
);

   logic                    valid_ff, valid_in;
   logic signed [KEY_W-1:0] value_ff, value_in;
   logic                    ins;

   assign ins = ctrl.push && (!valid_ff || (ctrl.key > value_ff));

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.pop) begin
         valid_in = right_link.valid;
         value_in = right_link.value;
      end else if (ins) begin
         if (left_link.ins) begin
            valid_in = left_link.valid;
            value_in = left_link.value;
         end else begin
            valid_in = 1'b1;
            value_in = ctrl.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign link.valid = valid_ff;
   assign link.ins   = ins;
   assign link.value = value_ff;

endmodule

// ===== rtl/max_heap_priority_queue_top.sv =====
// Bounded max-priority queue built as a chain of sorting cells.
// Depends on hpq_pkg and hpq_cell.
//
// Usage: each request transaction is a push (req_mode = 0, key in req_key_in)
// or a pop of the largest key (req_mode = 1). Every request yields exactly one
// response transaction carrying the largest stored key (zero when empty), the
// entry count, an empty flag and a status: ok, overflow on a push when full,
// or underflow on a pop when empty. Overflow and underflow leave the stored
// keys unchanged.
// The cells keep the keys sorted in descending order, so the maximum always
// sits in the first cell. A push compares the key against every cell in the
// same cycle and shifts the smaller keys one cell down; a pop shifts every
// cell one place up.
// The response is registered and appears in the cycle after its request is taken,
// and one request can be taken every cycle while responses are taken as fast.
// When the receiver stalls a waiting response, req_stall rises and holds off
// further requests until that response is taken.
// Reset is synchronous and active high; it empties the queue and drops any
// pending response.
module max_heap_priority_queue_top
   import hpq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic signed [KEY_W-1:0]  req_key_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [KEY_W-1:0]  rsp_max_key,
   output logic [ECNT_W-1:0]        rsp_entry_count,
   output logic                     rsp_is_empty,
   output logic [1:0]               rsp_status
);

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             full;
   logic             empty;
   cell_ctrl_type    ctrl;
   cell_link_type    links [CAPACITY+2];
   logic [CAPACITY-1:0] valid_vec;

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign ctrl.push = accept && (op_type'(req_mode) == OP_PUSH) && !full;
   assign ctrl.pop  = accept && (op_type'(req_mode) == OP_POP) && !empty;
   assign ctrl.key  = req_key_in;

   assign links[0]          = '0;
   assign links[CAPACITY+1] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      hpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_link  (links[i]),
         .right_link (links[i+2]),
         .link       (links[i+1])
      );
      assign valid_vec[i] = links[i+1].valid;
   end

   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         if (op_type'(req_mode) == OP_PUSH) begin
            if (full) begin
               status_in = ST_OVERFLOW;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               status_in = ST_UNDERFLOW;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         status_ff    <= ST_OK;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_max_key     = empty ? '0 : links[1].value;
   assign rsp_entry_count = ECNT_W'(count_ff);
   assign rsp_is_empty    = empty;
   assign rsp_status      = status_ff;

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("Cell valid bits disagree with the entry count.");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("Entry count exceeds capacity.");

   a_overflow_keeps_count: assert property (@(posedge clock) disable iff (reset)
      accept && (op_type'(req_mode) == OP_PUSH) && full
      |=> (status_ff == ST_OVERFLOW) && $stable(count_ff))
      else $error("Push on a full queue changed the count.");

   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      accept && (op_type'(req_mode) == OP_POP) && !empty
      |=> (count_ff == $past(count_ff) - 1'b1) && (status_ff == ST_OK))
      else $error("Pop did not remove exactly one entry.");

   a_head_is_max: assert property (@(posedge clock) disable iff (reset)
      links[2].valid |-> links[1].valid && (links[1].value >= links[2].value))
      else $error("First two cells are out of order.");

endmodule

// ===== verif/max_heap_priority_queue_top_test.sv =====
// Self-checking testbench for max_heap_priority_queue_top: push and pop transactions
// are checked against a heap model kept in the testbench. Uses hpq_pkg only for
// types and sizes; needs no files and no arguments.
module max_heap_priority_queue_top_test;
   import hpq_pkg::*;

   localparam int RANDOM_OPS  = 1700;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 30;

   typedef struct {
      op_type                  op;
      logic signed [KEY_W-1:0] key;
   } heap_op_type;

   typedef struct {
      logic signed [KEY_W-1:0] max_key;
      logic [ECNT_W-1:0]       entry_count;
      logic                    is_empty;
      status_type              status;
   } heap_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_mode = 1'b0;
   logic signed [KEY_W-1:0] req_key_in = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [KEY_W-1:0] rsp_max_key;
   logic [ECNT_W-1:0]       rsp_entry_count;
   logic                    rsp_is_empty;
   logic [1:0]              rsp_status;

   heap_op_type             pending_ops[$];
   heap_result_type         expected_results[$];
   heap_op_type             next_op;
   heap_result_type         got_result;

   logic signed [KEY_W-1:0] shadow_heap [1:CAPACITY];
   int                      shadow_count = 0;

   int gap_left = 0;
   int burst_left = 8;
   int stall_mode = 0;
   int stall_left = 0;
   int stall_phase = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int checked_count = 0;
   int n_push = 0;
   int n_pop = 0;
   int n_overflow = 0;
   int n_underflow = 0;
   int peak_depth = 0;
   int gen_depth = 0;

   max_heap_priority_queue_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_key_in      (req_key_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_max_key     (rsp_max_key),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic heap_result_type heap_apply(op_type op, logic signed [KEY_W-1:0] key);
      heap_result_type         res;
      int                      pos;
      int                      best;
      int                      lchild;
      int                      rchild;
      bit                      settled;
      logic signed [KEY_W-1:0] tmp;
      res.status = ST_OK;
      if (op == OP_PUSH) begin
         if (shadow_count >= CAPACITY) begin
            res.status = ST_OVERFLOW;
         end else begin
            shadow_count++;
            shadow_heap[shadow_count] = key;
            pos = shadow_count;
            while (pos > 1 && shadow_heap[pos] > shadow_heap[pos / 2]) begin
               tmp = shadow_heap[pos];
               shadow_heap[pos] = shadow_heap[pos / 2];
               shadow_heap[pos / 2] = tmp;
               pos = pos / 2;
            end
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = ST_UNDERFLOW;
         end else begin
            shadow_heap[1] = shadow_heap[shadow_count];
            shadow_count--;
            pos = 1;
            settled = (shadow_count == 0);
            while (!settled) begin
               best = pos;
               lchild = 2 * pos;
               rchild = lchild + 1;
               if (lchild <= shadow_count && shadow_heap[lchild] > shadow_heap[best]) begin
                  best = lchild;
               end
               if (rchild <= shadow_count && shadow_heap[rchild] > shadow_heap[best]) begin
                  best = rchild;
               end
               if (best == pos) begin
                  settled = 1'b1;
               end else begin
                  tmp = shadow_heap[pos];
                  shadow_heap[pos] = shadow_heap[best];
                  shadow_heap[best] = tmp;
                  pos = best;
               end
            end
         end
      end
      if (shadow_count > peak_depth) begin
         peak_depth = shadow_count;
      end
      res.max_key = (shadow_count > 0) ? shadow_heap[1] : '0;
      res.entry_count = ECNT_W'(shadow_count);
      res.is_empty = (shadow_count == 0);
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("Mismatch on response transaction %0d, %s: got %h, expected %h",
                  checked_count, what, got, want);
      end
   endtask

   task automatic check_response();
      heap_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("no request outstanding", rsp_max_key, '0);
      end else begin
         want = expected_results.pop_front();
         if (rsp_max_key !== want.max_key) begin
            report_mismatch("max_key", rsp_max_key, want.max_key);
         end
         if (rsp_entry_count !== want.entry_count) begin
            report_mismatch("entry_count", KEY_W'(rsp_entry_count), KEY_W'(want.entry_count));
         end
         if (rsp_is_empty !== want.is_empty) begin
            report_mismatch("is_empty", KEY_W'(rsp_is_empty), KEY_W'(want.is_empty));
         end
         if (rsp_status !== want.status) begin
            report_mismatch("status", KEY_W'(rsp_status), KEY_W'(want.status));
         end
      end
      checked_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_mode <= OP_PUSH;
         req_key_in <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            got_result = heap_apply(op_type'(req_mode), req_key_in);
            case (got_result.status)
               ST_OVERFLOW:  n_overflow++;
               ST_UNDERFLOW: n_underflow++;
               default: begin
                  if (op_type'(req_mode) == OP_PUSH) begin
                     n_push++;
                  end else begin
                     n_pop++;
                  end
               end
            endcase
            expected_results.insert(expected_results.size(), got_result);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               next_op = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_mode <= next_op.op;
               req_key_in <= next_op.key;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_response();
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
         end
         stall_left--;
         stall_phase = (stall_phase + 1) % 7;
         case (stall_mode)
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 9) < 7);
            3:       rsp_stall <= (stall_phase < 3);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, expected_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic queue_op(op_type op, logic signed [KEY_W-1:0] key);
      heap_op_type entry;
      entry.op = op;
      entry.key = key;
      pending_ops.insert(pending_ops.size(), entry);
      if (op == OP_PUSH && gen_depth < CAPACITY) begin
         gen_depth++;
      end else if (op == OP_POP && gen_depth > 0) begin
         gen_depth--;
      end
   endtask

   function automatic logic signed [KEY_W-1:0] random_key();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            case ($urandom_range(0, 4))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'hFFFF_FFFF;
               3:       return 32'h0000_0001;
               default: return '0;
            endcase
         end
         1, 2, 3: return $urandom_range(0, 16) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_idle();
      @(negedge clock);
      while (pending_ops.size() > 0 || req_valid || expected_results.size() > 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      int queued;
      int seg_len;
      int push_pct;
      int seg_idx;
      queued = 0;
      seg_idx = 0;
      reset <= 1'b1;
      queue_op(OP_POP, '0);
      queue_op(OP_PUSH, 32'h7FFF_FFFF);
      queue_op(OP_PUSH, 32'h8000_0000);
      queue_op(OP_PUSH, 32'h0000_0000);
      queue_op(OP_PUSH, 32'hFFFF_FFFF);
      queue_op(OP_PUSH, 32'h0000_0001);
      queue_op(OP_PUSH, 32'd5);
      queue_op(OP_PUSH, 32'd5);
      queue_op(OP_PUSH, 32'd5);
      queue_op(OP_PUSH, -32'sd5);
      queue_op(OP_POP, '0);
      queue_op(OP_POP, '0);
      queue_op(OP_POP, '0);
      queue_op(OP_POP, '0);
      queue_op(OP_PUSH, 32'h5555_AAAA);
      repeat (6) begin
         queue_op(OP_POP, '0);
      end
      queue_op(OP_POP, '0);
      queue_op(OP_PUSH, 32'hAAAA_5555);
      queue_op(OP_POP, '0);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait_idle();
      while (queued < RANDOM_OPS) begin
         seg_len = $urandom_range(20, 120);
         case ($urandom_range(0, 3))
            0:       push_pct = 85;
            1:       push_pct = 15;
            2:       push_pct = 50;
            default: push_pct = (gen_depth > CAPACITY / 2) ? 60 : 40;
         endcase
         repeat (seg_len) begin
            queue_op(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, random_key());
         end
         queued += seg_len;
         seg_idx++;
         if (seg_idx % 5 == 0) begin
            wait_idle();
         end
      end
      wait_idle();
      repeat (8) @(negedge clock);
      $display("Checked %0d response transactions: %0d pushes, %0d pops, %0d overflows,",
               checked_count, n_push, n_pop, n_overflow);
      $display("%0d underflows; queue depth peaked at %0d of %0d entries.",
               n_underflow, peak_depth, CAPACITY);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
